### design/iscv_pkg.sv
// Shared types, command codes and size defaults for the ISI channel convolver.
`timescale 1ns / 1ps

package iscv_pkg;

  // Default sizes of the channel model.
  localparam int DEF_SYMBOLS      = 4;
  localparam int DEF_TAPS         = 4;
  localparam int DEF_SAMPLE_WIDTH = 16;

  // Fixed field widths of the words on the ports.
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 6;
  localparam int VALUE_W = 16;
  localparam int OUT_W   = 34;

  // Command codes carried by an input word.
  typedef enum logic [CMD_W-1:0] {
    CMD_SYMBOL = 2'd0,
    CMD_TABLE  = 2'd1,
    CMD_TAP    = 2'd2,
    CMD_HIST   = 2'd3
  } iscv_cmd_t;

  // Decoded strobes for an accepted input word.
  typedef struct packed {
    logic sym_acc;
    logic tbl_we;
    logic tap_we;
    logic hist_we;
  } iscv_ctl_t;

endpackage

### design/isi_channel_symbol_convolver.sv
// Top level of the ISI channel convolver: handshake, sample stage and result register.
// A symbol word is looked up in the constellation and registered in the sample stage;
// the multiply-accumulate then feeds the result register. Throughput: one word per cycle
// while the sample stage is not blocked by a stalled result register.
// Reset (rst_n low, synchronous) clears the table, the taps, the history and all valids.
`timescale 1ns / 1ps

module isi_channel_symbol_convolver import iscv_pkg::*; #(
  parameter int SYMBOLS      = DEF_SYMBOLS,
  parameter int TAPS         = DEF_TAPS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic        [CMD_W-1:0]   in_cmd,
  input  logic        [INDEX_W-1:0] in_index,
  input  logic signed [VALUE_W-1:0] in_value_re,
  input  logic signed [VALUE_W-1:0] in_value_im,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OUT_W-1:0]   out_re,
  output logic signed [OUT_W-1:0]   out_im
);

  iscv_ctl_t ctl;
  logic      in_acc;
  logic      out_free;
  logic      s1_adv;
  logic      s1_valid_r;
  logic      out_valid_r;

  logic signed [SAMPLE_WIDTH-1:0] smp_re   [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] smp_im   [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] smp_re_r [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] smp_im_r [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] tap_re   [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] tap_im   [TAPS];
  logic signed [OUT_W-1:0]        acc_re;
  logic signed [OUT_W-1:0]        acc_im;
  logic signed [OUT_W-1:0]        out_re_r;
  logic signed [OUT_W-1:0]        out_im_r;

  // Handshake: the sample stage moves on when the result register is free or draining.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Decode an accepted word into state strobes.
  always_comb begin
    ctl = '0;
    unique case (iscv_cmd_t'(in_cmd))
      CMD_SYMBOL: ctl.sym_acc = in_acc;
      CMD_TABLE:  ctl.tbl_we  = in_acc;
      CMD_TAP:    ctl.tap_we  = in_acc;
      CMD_HIST:   ctl.hist_we = in_acc;
      default:    ctl = '0;
    endcase
  end

  iscv_state #(
    .SYMBOLS      (SYMBOLS),
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .in_index    (in_index),
    .in_value_re (in_value_re),
    .in_value_im (in_value_im),
    .smp_re      (smp_re),
    .smp_im      (smp_im),
    .tap_re      (tap_re),
    .tap_im      (tap_im)
  );

  // Sample stage: mapped symbols of an accepted symbol word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (ctl.sym_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sym_acc) begin
      smp_re_r <= smp_re;
      smp_im_r <= smp_im;
    end
  end

  iscv_mac #(
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .smp_re (smp_re_r),
    .smp_im (smp_im_r),
    .tap_re (tap_re),
    .tap_im (tap_im),
    .acc_re (acc_re),
    .acc_im (acc_im)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_re_r <= acc_re;
      out_im_r <= acc_im;
    end
  end

  assign out_valid = out_valid_r;
  assign out_re    = out_re_r;
  assign out_im    = out_im_r;

  // A symbol word always lands in the sample stage.
  a_sym_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.sym_acc |=> s1_valid_r)
    else $error("symbol word did not reach the sample stage");

  // Set-up words never create a result.
  a_setup_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd != CMD_SYMBOL) && !s1_valid_r) |=> !s1_valid_r)
    else $error("set-up word produced a result");

  // A word leaving the sample stage shows up in the result register.
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("sample stage advanced without a result");

  // No new word is taken while the sample stage is blocked.
  a_block_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |-> !in_acc)
    else $error("word accepted while the sample stage was blocked");

endmodule

### design/iscv_state.sv
// Constellation table, channel taps, symbol history and per-tap symbol lookup.
`timescale 1ns / 1ps

module iscv_state import iscv_pkg::*; #(
  parameter int SYMBOLS      = DEF_SYMBOLS,
  parameter int TAPS         = DEF_TAPS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  iscv_ctl_t                      ctl,
  input  logic        [INDEX_W-1:0]      in_index,
  input  logic signed [VALUE_W-1:0]      in_value_re,
  input  logic signed [VALUE_W-1:0]      in_value_im,
  output logic signed [SAMPLE_WIDTH-1:0] smp_re [TAPS],
  output logic signed [SAMPLE_WIDTH-1:0] smp_im [TAPS],
  output logic signed [SAMPLE_WIDTH-1:0] tap_re [TAPS],
  output logic signed [SAMPLE_WIDTH-1:0] tap_im [TAPS]
);

  // Bits per symbol group is floor(log2(SYMBOLS)).
  localparam int B      = $clog2(SYMBOLS + 1) - 1;
  localparam int IDX_W  = $clog2(SYMBOLS);
  localparam int HIST_W = B * (TAPS - 1);
  localparam int E_W    = B * TAPS;
  localparam logic [B-1:0] SYM_MASK_B = B'(SYMBOLS - 1);

  logic signed [SAMPLE_WIDTH-1:0] con_re_r [SYMBOLS];
  logic signed [SAMPLE_WIDTH-1:0] con_im_r [SYMBOLS];
  logic signed [SAMPLE_WIDTH-1:0] tap_re_r [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] tap_im_r [TAPS];
  logic [B-1:0]   sym_b;
  logic [E_W-1:0] e_w;

  // Sign-extend or trim a 16-bit value to the sample width.
  function automatic logic signed [SAMPLE_WIDTH-1:0] to_smp(input logic [VALUE_W-1:0] v);
    return SAMPLE_WIDTH'($signed(v));
  endfunction

  // Constellation entries; writes beyond the table are dropped by the decode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SYMBOLS; i++) begin
        con_re_r[i] <= '0;
        con_im_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < SYMBOLS; i++) begin
        if (ctl.tbl_we && (in_index == INDEX_W'(i))) begin
          con_re_r[i] <= to_smp(in_value_re);
          con_im_r[i] <= to_smp(in_value_im);
        end
      end
    end
  end

  // Channel taps; writes beyond the last tap are dropped by the decode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        tap_re_r[i] <= '0;
        tap_im_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < TAPS; i++) begin
        if (ctl.tap_we && (in_index == INDEX_W'(i))) begin
          tap_re_r[i] <= to_smp(in_value_re);
          tap_im_r[i] <= to_smp(in_value_im);
        end
      end
    end
  end

  // The new symbol keeps only its low group bits under the symbol mask.
  assign sym_b = in_index[B-1:0] & SYM_MASK_B;

  // History of past symbols, oldest in the low group; the new symbol goes on top.
  if (TAPS > 1) begin : g_hist
    logic [HIST_W-1:0] hist_r;

    assign e_w = {sym_b, hist_r};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hist_r <= '0;
      end else if (ctl.hist_we) begin
        hist_r <= HIST_W'(in_index);
      end else if (ctl.sym_acc) begin
        hist_r <= e_w[E_W-1:B];
      end
    end
  end else begin : g_nohist
    assign e_w = sym_b;
  end

  // Tap k maps the symbol in group TAPS-1-k through the constellation.
  for (genvar k = 0; k < TAPS; k++) begin : g_lookup
    logic [B-1:0]     grp;
    logic [IDX_W-1:0] sel;

    assign grp       = e_w[(TAPS-1-k)*B +: B] & SYM_MASK_B;
    assign sel       = IDX_W'(grp);
    assign smp_re[k] = con_re_r[sel];
    assign smp_im[k] = con_im_r[sel];
    assign tap_re[k] = tap_re_r[k];
    assign tap_im[k] = tap_im_r[k];
  end

endmodule

### design/iscv_mac.sv
// Complex multiply-accumulate of mapped symbols against the channel taps.
`timescale 1ns / 1ps

module iscv_mac import iscv_pkg::*; #(
  parameter int TAPS         = DEF_TAPS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic signed [SAMPLE_WIDTH-1:0] smp_re [TAPS],
  input  logic signed [SAMPLE_WIDTH-1:0] smp_im [TAPS],
  input  logic signed [SAMPLE_WIDTH-1:0] tap_re [TAPS],
  input  logic signed [SAMPLE_WIDTH-1:0] tap_im [TAPS],
  output logic signed [OUT_W-1:0]        acc_re,
  output logic signed [OUT_W-1:0]        acc_im
);

  localparam int P_W = 2 * SAMPLE_WIDTH;

  logic signed [OUT_W-1:0] term_re [TAPS];
  logic signed [OUT_W-1:0] term_im [TAPS];

  // One complex product per tap; each product is sign-extended to the output width, which
  // keeps the final sum exact modulo the output range.
  for (genvar k = 0; k < TAPS; k++) begin : g_prod
    logic signed [P_W-1:0] p_rr;
    logic signed [P_W-1:0] p_ii;
    logic signed [P_W-1:0] p_ri;
    logic signed [P_W-1:0] p_ir;

    assign p_rr       = tap_re[k] * smp_re[k];
    assign p_ii       = tap_im[k] * smp_im[k];
    assign p_ri       = tap_re[k] * smp_im[k];
    assign p_ir       = tap_im[k] * smp_re[k];
    assign term_re[k] = OUT_W'(p_rr) - OUT_W'(p_ii);
    assign term_im[k] = OUT_W'(p_ri) + OUT_W'(p_ir);
  end

  // Sum of the tap terms.
  always_comb begin
    acc_re = '0;
    acc_im = '0;
    for (int k = 0; k < TAPS; k++) begin
      acc_re = acc_re + term_re[k];
      acc_im = acc_im + term_im[k];
    end
  end

endmodule

### verif/isi_channel_symbol_convolver_test.sv
// Self-checking testbench for the ISI channel symbol convolver.
`timescale 1ns / 1ps

module isi_channel_symbol_convolver_test;
  import iscv_pkg::*;

  localparam int SYM_BITS = $clog2(DEF_SYMBOLS);
  localparam int HIST_W   = SYM_BITS * (DEF_TAPS - 1);
  localparam int EXT_W    = HIST_W + SYM_BITS;

  // One complex channel output as it appears on the result ports.
  typedef struct packed {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
  } channel_out_t;

  // Tracks the channel state, predicts each output and checks what the block returns.
  class channel_output_tracker;
    logic signed [VALUE_W-1:0] point_re [DEF_SYMBOLS];
    logic signed [VALUE_W-1:0] point_im [DEF_SYMBOLS];
    logic signed [VALUE_W-1:0] tap_re [DEF_TAPS];
    logic signed [VALUE_W-1:0] tap_im [DEF_TAPS];
    logic [HIST_W-1:0]         history;
    channel_out_t              pending_outputs [$];
    int                        mismatches;

    function new();
      foreach (point_re[i]) begin
        point_re[i] = '0;
        point_im[i] = '0;
      end
      foreach (tap_re[i]) begin
        tap_re[i] = '0;
        tap_im[i] = '0;
      end
      history    = '0;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    // Apply an accepted input word; a symbol word yields one predicted output.
    function void note_word(iscv_cmd_t cmd, logic [INDEX_W-1:0] index,
                            logic signed [VALUE_W-1:0] vre,
                            logic signed [VALUE_W-1:0] vim);
      logic [EXT_W-1:0]    ext;
      logic [SYM_BITS-1:0] sym;
      longint              acc_re;
      longint              acc_im;
      channel_out_t        want;
      case (cmd)
        CMD_TABLE: begin
          if (index < DEF_SYMBOLS) begin
            point_re[index] = vre;
            point_im[index] = vim;
          end
        end
        CMD_TAP: begin
          if (index < DEF_TAPS) begin
            tap_re[index] = vre;
            tap_im[index] = vim;
          end
        end
        CMD_HIST: history = index[HIST_W-1:0];
        default: begin
          // The new symbol sits above the history; tap 0 takes the newest group.
          ext    = {index[SYM_BITS-1:0], history};
          acc_re = 0;
          acc_im = 0;
          for (int k = 0; k < DEF_TAPS; k++) begin
            sym = ext[(DEF_TAPS-1-k)*SYM_BITS +: SYM_BITS];
            acc_re += longint'(tap_re[k]) * longint'(point_re[sym])
                    - longint'(tap_im[k]) * longint'(point_im[sym]);
            acc_im += longint'(tap_re[k]) * longint'(point_im[sym])
                    + longint'(tap_im[k]) * longint'(point_re[sym]);
          end
          history = ext[SYM_BITS +: HIST_W];
          want.re = acc_re[OUT_W-1:0];
          want.im = acc_im[OUT_W-1:0];
          pending_outputs.push_back(want);
        end
      endcase
    endfunction

    // Compare an accepted output word with the oldest prediction.
    function void check_output(logic signed [OUT_W-1:0] got_re,
                               logic signed [OUT_W-1:0] got_im);
      channel_out_t want;
      if (pending_outputs.size() == 0) begin
        flag($sformatf("unexpected output re %0d im %0d", got_re, got_im));
        return;
      end
      want = pending_outputs.pop_front();
      if (got_re !== want.re)
        flag($sformatf("out_re expected %0d got %0d", want.re, got_re));
      if (got_im !== want.im)
        flag($sformatf("out_im expected %0d got %0d", want.im, got_im));
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic        [CMD_W-1:0]   in_cmd = '0;
  logic        [INDEX_W-1:0] in_index = '0;
  logic signed [VALUE_W-1:0] in_value_re = '0;
  logic signed [VALUE_W-1:0] in_value_im = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [OUT_W-1:0]   out_re;
  logic signed [OUT_W-1:0]   out_im;

  int snd_idle_pct = 22;
  int rcv_idle_pct = 84;

  channel_output_tracker channel_model = new();

  isi_channel_symbol_convolver u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_index    (in_index),
    .in_value_re (in_value_re),
    .in_value_im (in_value_im),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_re      (out_re),
    .out_im      (out_im)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < rcv_idle_pct);
  end

  // Every output word taken by the receiver is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) channel_model.check_output(out_re, out_im);
  end

  // Present one word from a falling edge and hold it until accepted.
  task automatic send_word(iscv_cmd_t cmd, logic [INDEX_W-1:0] index,
                           logic signed [VALUE_W-1:0] vre,
                           logic signed [VALUE_W-1:0] vim);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_cmd      = cmd;
    in_index    = index;
    in_value_re = vre;
    in_value_im = vim;
    in_valid    = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    channel_model.note_word(cmd, index, vre, vim);
    @(negedge clk);
  endtask

  // Mostly uniform values, with the extremes and zero mixed in.
  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Symbols dominate; table and tap writes mostly hit valid entries.
  task automatic send_random_word();
    int                 pick;
    iscv_cmd_t          cmd;
    logic [INDEX_W-1:0] index;
    pick = $urandom_range(0, 99);
    if (pick < 60) cmd = CMD_SYMBOL;
    else if (pick < 75) cmd = CMD_TABLE;
    else if (pick < 90) cmd = CMD_TAP;
    else cmd = CMD_HIST;
    index = INDEX_W'($urandom_range(0, 63));
    if ((cmd == CMD_TABLE || cmd == CMD_TAP) && $urandom_range(0, 4) != 0)
      index = INDEX_W'($urandom_range(0, DEF_SYMBOLS - 1));
    send_word(cmd, index, random_value(), random_value());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words: reset state, extremes, ignored writes, history and overflow.
    send_word(CMD_SYMBOL, 6'd0, 16'sd0, 16'sd0);
    send_word(CMD_TABLE, 6'd0, 16'sh7fff, 16'sh8000);
    send_word(CMD_TABLE, 6'd1, 16'sh8000, 16'sh7fff);
    send_word(CMD_TABLE, 6'd2, 16'sh8000, 16'sh8000);
    send_word(CMD_TABLE, 6'd3, 16'sd1, -16'sd1);
    send_word(CMD_TABLE, 6'd4, 16'sd1234, -16'sd1234);
    send_word(CMD_TABLE, 6'd63, 16'sh7fff, 16'sh7fff);
    send_word(CMD_TAP, 6'd0, 16'sh8000, 16'sh8000);
    send_word(CMD_TAP, 6'd1, 16'sh7fff, 16'sh7fff);
    send_word(CMD_TAP, 6'd2, 16'sh8000, 16'sh7fff);
    send_word(CMD_TAP, 6'd3, -16'sd1, 16'sd16384);
    send_word(CMD_TAP, 6'd4, 16'sd777, 16'sd777);
    send_word(CMD_TAP, 6'd63, 16'sh8000, 16'sh8000);
    send_word(CMD_SYMBOL, 6'd63, 16'sd0, 16'sd0);
    send_word(CMD_HIST, 6'd63, 16'sd0, 16'sd0);
    send_word(CMD_SYMBOL, 6'd3, 16'sd0, 16'sd0);
    send_word(CMD_SYMBOL, 6'd1, 16'sd0, 16'sd0);
    // All taps and the selected point at the most negative value wrap the output.
    send_word(CMD_TAP, 6'd1, 16'sh8000, 16'sh8000);
    send_word(CMD_TAP, 6'd2, 16'sh8000, 16'sh8000);
    send_word(CMD_TAP, 6'd3, 16'sh8000, 16'sh8000);
    send_word(CMD_HIST, 6'd42, 16'sd0, 16'sd0);
    send_word(CMD_SYMBOL, 6'd2, 16'sd0, 16'sd0);
    send_word(CMD_SYMBOL, 6'd6, 16'sd0, 16'sd0);
    send_word(CMD_HIST, 6'd0, 16'sd0, 16'sd0);
    send_word(CMD_SYMBOL, 6'd0, 16'sd0, 16'sd0);

    // Random words under three back-pressure mixes.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct = 22;
          rcv_idle_pct = 84;
        end
        1: begin
          snd_idle_pct = 84;
          rcv_idle_pct = 22;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      repeat (150) send_random_word();
    end
    in_valid = 1'b0;

    // Drain the pipeline, then wait for stray outputs.
    while (channel_model.pending_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (channel_model.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
